FILE: sv/ssfl_pkg.sv
// shared types, codes and helpers for the substring search unit
`timescale 1ns / 1ps
`default_nettype none

package ssfl_pkg;

    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_APPEND = 2'd1,
        ACT_TEXT   = 2'd2,
        ACT_FINISH = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_PAT_OVF  = 2'd1,
        ST_TEXT_OVF = 2'd2
    } status_t;

    localparam int unsigned REG_CASE_FOLD  = 0;
    localparam int unsigned REG_FROM_END   = 1;
    localparam int unsigned CFG_INDEX_BITS = 2;

    localparam int unsigned PORT_CHAR_BITS = 16;
    localparam int unsigned POS_BITS       = 20;

    localparam logic [PORT_CHAR_BITS-1:0] CHAR_UPPER_A = 16'h0041;
    localparam logic [PORT_CHAR_BITS-1:0] CHAR_UPPER_Z = 16'h005A;
    localparam logic [PORT_CHAR_BITS-1:0] CHAR_LOWER_A = 16'h0061;

    typedef struct packed {
        logic restart;
        logic step;
        logic fold;
    } cell_ctrl_t;

    function automatic logic [PORT_CHAR_BITS-1:0] fold_char(
        input logic [PORT_CHAR_BITS-1:0] c,
        input logic                      en
    );
        logic [PORT_CHAR_BITS-1:0] r;
        r = c;
        if (en && c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
            r = c - CHAR_UPPER_A + CHAR_LOWER_A;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: sv/ssfl_cell.sv
// one pattern position: stored character and its partial-match bit
`timescale 1ns / 1ps
`default_nettype none

module ssfl_cell #(
    parameter int unsigned CW = 16
) (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  ssfl_pkg::cell_ctrl_t                 ctrl,
    input  wire                                  load,
    input  wire  [CW-1:0]                        load_char,
    input  wire                                  active,
    input  wire                                  last,
    input  wire  [ssfl_pkg::PORT_CHAR_BITS-1:0]  text_char,
    input  wire                                  prev_match,
    output logic                                 match,
    output logic                                 tail_hit
);
    import ssfl_pkg::*;

    logic [CW-1:0] char_reg;
    logic          match_reg;
    logic          match_next;
    logic          eq;

    assign eq = fold_char(PORT_CHAR_BITS'(char_reg), ctrl.fold) == text_char;

    always_comb begin
        match_next = match_reg;
        if (ctrl.restart) begin
            match_next = 1'b0;
        end else if (ctrl.step) begin
            match_next = active && prev_match && eq;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_reg <= 1'b0;
        end else begin
            match_reg <= match_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            char_reg <= load_char;
        end
    end

    assign match    = match_reg;
    assign tail_hit = ctrl.step && active && last && prev_match && eq;

endmodule

`default_nettype wire

FILE: sv/substring_search_first_or_last_unit.sv
// top level: pattern cell chain, search bookkeeping and result queue
//
// Exact substring search over a stream of 16-bit characters. Pattern
// characters are loaded one word at a time into a chain of MAX_PATTERN
// cells; each text word is compared against every cell at once and the
// partial-match bits move one cell along, so one word is taken every
// cycle while not stalled. A finish word produces one result word. The
// result side holds two words, so input stalls only when two results
// are waiting untaken. case_fold folds A-Z to a-z on both sides;
// search_from_end selects the rightmost instead of the leftmost match.
`timescale 1ns / 1ps
`default_nettype none

module substring_search_first_or_last_unit #(
    parameter int unsigned MAX_PATTERN     = 32,
    parameter int unsigned TEXT_INDEX_BITS = 20,
    parameter int unsigned CHAR_BITS       = 16
) (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  wire                                  s_tvalid,
    output logic                                 s_tready,
    input  wire  [15:0]                          s_tdata,   // char_value
    input  wire  [1:0]                           s_tuser,   // action
    output logic                                 m_tvalid,
    input  wire                                  m_tready,
    output logic [23:0]                          m_tdata,   // found, position, zero pad
    output logic [1:0]                           m_tuser,   // status
    input  wire                                  cfg_valid,
    output logic                                 cfg_ready,
    input  wire  [ssfl_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire                                  cfg_data
);
    import ssfl_pkg::*;

    localparam int unsigned CW  = (CHAR_BITS < PORT_CHAR_BITS) ? CHAR_BITS : PORT_CHAR_BITS;
    localparam int unsigned LW  = $clog2(MAX_PATTERN + 1);
    localparam int unsigned TIB = TEXT_INDEX_BITS;

    logic           fold_reg, from_end_reg;
    logic [LW-1:0]  len_reg, len_next;
    logic           povf_reg, povf_next;
    logic           tovf_reg, tovf_next;
    logic [TIB-1:0] count_reg, count_next;
    logic           hit_seen_reg, hit_seen_next;
    logic [TIB-1:0] hit_pos_reg, hit_pos_next;

    logic                out_valid_reg, out_valid_next;
    logic                skid_valid_reg, skid_valid_next;
    logic [POS_BITS:0]   out_data_reg, out_data_next;
    logic [POS_BITS:0]   skid_data_reg, skid_data_next;
    status_t             out_status_reg, out_status_next;
    status_t             skid_status_reg, skid_status_next;

    logic                      s_fire, m_fire;
    action_t                   action;
    logic [CW-1:0]             char_in;
    logic [PORT_CHAR_BITS-1:0] text_folded;
    cell_ctrl_t                ctrl;
    logic                      text_full;
    logic [MAX_PATTERN-1:0]    match, tail, load, active, last;
    logic                      any_tail;
    logic [TIB-1:0]            start_pos;
    logic                      res_found;
    logic [POS_BITS-1:0]       res_pos;
    status_t                   res_status;

    assign s_fire      = s_tvalid && s_tready;
    assign m_fire      = m_tvalid && m_tready;
    assign action      = action_t'(s_tuser);
    assign char_in     = s_tdata[CW-1:0];
    assign text_folded = fold_char(PORT_CHAR_BITS'(char_in), fold_reg);
    assign text_full   = &count_reg;
    assign start_pos   = count_reg + TIB'(1) - TIB'(len_reg);
    assign any_tail    = |tail;

    assign ctrl.fold    = fold_reg;
    assign ctrl.step    = s_fire && (action == ACT_TEXT) && !text_full;
    assign ctrl.restart = s_fire && (action != ACT_TEXT);

    genvar k;
    generate
        for (k = 0; k < MAX_PATTERN; k++) begin : g_cell
            assign load[k]   = s_fire && (action == ACT_APPEND) && (len_reg == LW'(k));
            assign active[k] = LW'(k) < len_reg;
            assign last[k]   = LW'(k + 1) == len_reg;
            ssfl_cell #(.CW(CW)) u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctrl       (ctrl),
                .load       (load[k]),
                .load_char  (char_in),
                .active     (active[k]),
                .last       (last[k]),
                .text_char  (text_folded),
                .prev_match ((k == 0) ? 1'b1 : match[(k == 0) ? 0 : k - 1]),
                .match      (match[k]),
                .tail_hit   (tail[k])
            );
        end
    endgenerate

    always_comb begin
        res_found  = 1'b0;
        res_pos    = '0;
        res_status = ST_OK;
        priority if (povf_reg) begin
            res_status = ST_PAT_OVF;
        end else if (tovf_reg) begin
            res_status = ST_TEXT_OVF;
        end else if (len_reg == '0) begin
            res_found = 1'b1;
            res_pos   = from_end_reg ? POS_BITS'(count_reg) : '0;
        end else if (hit_seen_reg) begin
            res_found = 1'b1;
            res_pos   = POS_BITS'(hit_pos_reg);
        end
    end

    always_comb begin
        len_next      = len_reg;
        povf_next     = povf_reg;
        tovf_next     = tovf_reg;
        count_next    = count_reg;
        hit_seen_next = hit_seen_reg;
        hit_pos_next  = hit_pos_reg;
        if (s_fire) begin
            unique case (action)
                ACT_CLEAR: begin
                    len_next  = '0;
                    povf_next = 1'b0;
                end
                ACT_APPEND: begin
                    if (len_reg < LW'(MAX_PATTERN)) begin
                        len_next = len_reg + LW'(1);
                    end else begin
                        povf_next = 1'b1;
                    end
                end
                ACT_TEXT: begin
                    if (text_full) begin
                        tovf_next = 1'b1;
                    end else begin
                        count_next = count_reg + TIB'(1);
                        if (any_tail && (from_end_reg || !hit_seen_reg)) begin
                            hit_seen_next = 1'b1;
                            hit_pos_next  = start_pos;
                        end
                    end
                end
                ACT_FINISH: begin
                end
                default: begin
                end
            endcase
            if (action != ACT_TEXT) begin
                tovf_next     = 1'b0;
                count_next    = '0;
                hit_seen_next = 1'b0;
                hit_pos_next  = '0;
            end
        end
    end

    always_comb begin
        out_valid_next   = out_valid_reg;
        out_data_next    = out_data_reg;
        out_status_next  = out_status_reg;
        skid_valid_next  = skid_valid_reg;
        skid_data_next   = skid_data_reg;
        skid_status_next = skid_status_reg;
        if (m_fire) begin
            if (skid_valid_reg) begin
                out_data_next   = skid_data_reg;
                out_status_next = skid_status_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = 1'b0;
            end
        end
        if (s_fire && action == ACT_FINISH) begin
            if (out_valid_reg && !m_fire) begin
                skid_valid_next  = 1'b1;
                skid_data_next   = {res_pos, res_found};
                skid_status_next = res_status;
            end else begin
                out_valid_next  = 1'b1;
                out_data_next   = {res_pos, res_found};
                out_status_next = res_status;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fold_reg       <= 1'b0;
            from_end_reg   <= 1'b0;
            len_reg        <= '0;
            povf_reg       <= 1'b0;
            tovf_reg       <= 1'b0;
            count_reg      <= '0;
            hit_seen_reg   <= 1'b0;
            hit_pos_reg    <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_INDEX_BITS'(REG_CASE_FOLD)) begin
                    fold_reg <= cfg_data;
                end
                if (cfg_index == CFG_INDEX_BITS'(REG_FROM_END)) begin
                    from_end_reg <= cfg_data;
                end
            end
            len_reg        <= len_next;
            povf_reg       <= povf_next;
            tovf_reg       <= tovf_next;
            count_reg      <= count_next;
            hit_seen_reg   <= hit_seen_next;
            hit_pos_reg    <= hit_pos_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg    <= out_data_next;
        out_status_reg  <= out_status_next;
        skid_data_reg   <= skid_data_next;
        skid_status_reg <= skid_status_next;
    end

    assign s_tready  = !skid_valid_reg;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {(24 - POS_BITS - 1)'(0), out_data_reg};
    assign m_tuser   = out_status_reg;

endmodule

`default_nettype wire

FILE: sv/ssfl_checker.sv
// port-level checks for the substring search unit, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module ssfl_port_checks (
    input wire        aclk,
    input wire        aresetn,
    input wire        s_tvalid,
    input wire        s_tready,
    input wire [1:0]  s_tuser,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [23:0] m_tdata,
    input wire [1:0]  m_tuser
);
    import ssfl_pkg::*;

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_result_from_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tuser == ACT_FINISH))
        else $error("result without a finish word");

    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result waiting");

    a_error_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != ST_OK |-> m_tdata[0] == 1'b0 && m_tdata[20:1] == '0)
        else $error("error result carries a match");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

endmodule

bind substring_search_first_or_last_unit ssfl_port_checks u_ssfl_port_checks (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

FILE: verif/ssfl_checker.sv
// checker for the substring search unit: tracks the search, predicts each result word and compares
`timescale 1ns / 1ps

module ssfl_checker
    import ssfl_pkg::*;
(
    input  wire                       aclk,
    input  wire                       aresetn,
    input  wire                       s_tvalid,
    input  wire                       s_tready,
    input  wire  [15:0]               s_tdata,
    input  wire  [1:0]                s_tuser,
    input  wire                       m_tvalid,
    input  wire                       m_tready,
    input  wire  [23:0]               m_tdata,
    input  wire  [1:0]                m_tuser,
    input  wire                       cfg_valid,
    input  wire                       cfg_ready,
    input  wire  [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire                       cfg_data,
    output int                        fail_count,
    output int                        due_count
);

    localparam int PATTERN_SLOTS = 32;
    localparam int unsigned TEXT_CAP = (1 << POS_BITS) - 1;

    typedef struct packed {
        logic                found;
        logic [POS_BITS-1:0] position;
        status_t             status;
    } search_report_t;

    search_report_t reports_due[$];

    logic [PORT_CHAR_BITS-1:0] pat_chars [PATTERN_SLOTS];
    int                        pat_len;
    bit [PATTERN_SLOTS-1:0]    partial;
    int unsigned               text_len;
    bit                        hit_seen;
    logic [POS_BITS-1:0]       hit_at;
    bit                        pat_ovf;
    bit                        text_ovf;
    bit                        fold_on;
    bit                        from_end;
    int                        fail_tally;

    assign fail_count = fail_tally;

    function automatic logic [PORT_CHAR_BITS-1:0] lower_ascii(input logic [PORT_CHAR_BITS-1:0] c);
        if (fold_on && c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
            return CHAR_LOWER_A + (c - CHAR_UPPER_A);
        end
        return c;
    endfunction

    task automatic restart_text_scan();
        partial  = '0;
        text_len = 0;
        hit_seen = 1'b0;
        hit_at   = '0;
        text_ovf = 1'b0;
    endtask

    task automatic advance_search(input action_t act, input logic [PORT_CHAR_BITS-1:0] ch);
        logic [PORT_CHAR_BITS-1:0] t;
        bit                        prev;
        search_report_t            r;
        case (act)
            ACT_CLEAR: begin
                pat_len = 0;
                pat_ovf = 1'b0;
                restart_text_scan();
            end
            ACT_APPEND: begin
                if (pat_len < PATTERN_SLOTS) begin
                    pat_chars[pat_len] = ch;
                    pat_len++;
                end else begin
                    pat_ovf = 1'b1;
                end
                restart_text_scan();
            end
            ACT_TEXT: begin
                if (text_len >= TEXT_CAP) begin
                    text_ovf = 1'b1;
                end else begin
                    t = lower_ascii(ch);
                    // top down, so each slot sees the old bit below it
                    for (int k = pat_len - 1; k >= 0; k--) begin
                        prev = (k == 0) ? 1'b1 : partial[k-1];
                        partial[k] = prev && (lower_ascii(pat_chars[k]) == t);
                    end
                    if (pat_len > 0 && partial[pat_len-1] && (from_end || !hit_seen)) begin
                        hit_at   = POS_BITS'(text_len + 1 - pat_len);
                        hit_seen = 1'b1;
                    end
                    text_len++;
                end
            end
            default: begin
                r = '{found: 1'b0, position: '0, status: ST_OK};
                if (pat_ovf) begin
                    r.status = ST_PAT_OVF;
                end else if (text_ovf) begin
                    r.status = ST_TEXT_OVF;
                end else if (pat_len == 0) begin
                    r.found    = 1'b1;
                    r.position = from_end ? POS_BITS'(text_len) : '0;
                end else if (hit_seen) begin
                    r.found    = 1'b1;
                    r.position = hit_at;
                end
                reports_due.push_back(r);
                restart_text_scan();
            end
        endcase
    endtask

    always @(posedge aclk) begin
        search_report_t want;
        if (!aresetn) begin
            reports_due.delete();
            pat_len    = 0;
            pat_ovf    = 1'b0;
            fold_on    = 1'b0;
            from_end   = 1'b0;
            fail_tally = 0;
            restart_text_scan();
        end else begin
            // results first: a word leaving now never belongs to a word arriving now
            if (m_tvalid && m_tready) begin
                if (reports_due.size() == 0) begin
                    $display("%0t: unexpected result word, found %0d position %0d status %0d",
                             $time, m_tdata[0], m_tdata[POS_BITS:1], m_tuser);
                    fail_tally++;
                end else begin
                    want = reports_due.pop_front();
                    if (m_tdata[0] !== want.found) begin
                        $display("%0t: found mismatch, expected %0d, actual %0d",
                                 $time, want.found, m_tdata[0]);
                        fail_tally++;
                    end
                    if (m_tdata[POS_BITS:1] !== want.position) begin
                        $display("%0t: position mismatch, expected %0d, actual %0d",
                                 $time, want.position, m_tdata[POS_BITS:1]);
                        fail_tally++;
                    end
                    if (m_tuser !== want.status) begin
                        $display("%0t: status mismatch, expected %0d, actual %0d",
                                 $time, want.status, m_tuser);
                        fail_tally++;
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_CASE_FOLD: fold_on  = cfg_data;
                    REG_FROM_END:  from_end = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                advance_search(action_t'(s_tuser), s_tdata);
            end
        end
        due_count <= reports_due.size();
    end

endmodule

FILE: verif/tb_top.sv
// testbench top for the substring search unit: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_top;
    import ssfl_pkg::*;

    localparam int PATTERN_SLOTS = 32;
    localparam int WORD_TARGET   = 880;
    localparam int HOLD_CYCLES   = 200;
    localparam int SETTLE_CYCLES = 4;
    localparam int END_CYCLES    = 8;
    localparam int DRAIN_LIMIT   = 20000;
    localparam logic [PORT_CHAR_BITS-1:0] CASE_BIT = 16'h0020;

    logic                      aclk = 1'b0;
    logic                      aresetn;
    logic                      s_tvalid;
    logic                      s_tready;
    logic [15:0]               s_tdata;
    logic [1:0]                s_tuser;
    logic                      m_tvalid;
    logic                      m_tready;
    logic [23:0]               m_tdata;
    logic [1:0]                m_tuser;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic                      cfg_data;
    int                        fail_count;
    int                        due_count;

    bit steady_tx;
    bit steady_rx;
    bit hold_rx;
    int words_sent;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    substring_search_first_or_last_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ssfl_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .due_count  (due_count)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [PORT_CHAR_BITS-1:0] pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return CHAR_LOWER_A + 16'($urandom_range(0, 2));
        if (r < 70) return CHAR_UPPER_A + 16'($urandom_range(0, 2));
        if (r < 85) begin
            // just outside and at the ends of the folded range
            case ($urandom_range(0, 5))
                0: return 16'h0040;
                1: return 16'h005A;
                2: return 16'h005B;
                3: return 16'h0060;
                4: return 16'h007A;
                default: return 16'h007B;
            endcase
        end
        return 16'($urandom_range(0, 65535));
    endfunction

    function automatic logic [PORT_CHAR_BITS-1:0] vary_case(input logic [PORT_CHAR_BITS-1:0] c);
        if (((c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ||
             (c >= CHAR_LOWER_A && c <= CHAR_LOWER_A + 25)) && $urandom_range(0, 1) == 1) begin
            return c ^ CASE_BIT;
        end
        return c;
    endfunction

    task automatic send_word(input action_t act, input logic [PORT_CHAR_BITS-1:0] ch);
        int gap;
        gap = steady_tx ? 0 : pick_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= ch;
        do @(posedge aclk); while (!s_tready);
        words_sent++;
    endtask

    // stop sending and wait for every outstanding result word
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (due_count != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input int unsigned idx, input logic val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_INDEX_BITS'(idx);
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_regs(input logic fold, input logic rightmost);
        write_reg(REG_CASE_FOLD, fold);
        write_reg(REG_FROM_END, rightmost);
    endtask

    task automatic run_session();
        int r;
        int plen;
        int tlen;
        int at;
        logic [PORT_CHAR_BITS-1:0] pat[$];
        logic [PORT_CHAR_BITS-1:0] txt[$];
        r = $urandom_range(0, 99);
        if (r < 6) plen = 0;
        else if (r < 12) plen = PATTERN_SLOTS + $urandom_range(1, 2);
        else if (r < 18) plen = PATTERN_SLOTS;
        else plen = $urandom_range(1, 4);
        if ($urandom_range(0, 9) != 0) send_word(ACT_CLEAR, 16'($urandom));
        for (int i = 0; i < plen; i++) begin
            pat.push_back(pick_char());
            send_word(ACT_APPEND, pat[i]);
        end
        repeat ($urandom_range(1, 3)) begin
            tlen = (plen > 8) ? $urandom_range(0, 48) : $urandom_range(0, 16);
            txt.delete();
            repeat (tlen) txt.push_back(pick_char());
            if (plen > 0 && plen <= PATTERN_SLOTS && $urandom_range(0, 3) != 0) begin
                repeat ($urandom_range(1, 2)) begin
                    at = $urandom_range(0, txt.size());
                    for (int k = 0; k < plen; k++) txt.insert(at + k, vary_case(pat[k]));
                end
            end
            foreach (txt[i]) begin
                if ($urandom_range(0, 49) == 0) begin
                    case ($urandom_range(0, 2))
                        0: send_word(ACT_CLEAR, pick_char());
                        1: send_word(ACT_APPEND, pick_char());
                        default: send_word(ACT_FINISH, pick_char());
                    endcase
                end
                send_word(ACT_TEXT, txt[i]);
            end
            send_word(ACT_FINISH, 16'($urandom));
        end
    endtask

    // result side: random stalls, and a long hold-off on request
    initial begin
        int stall_left;
        stall_left = 0;
        m_tready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_rx) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_rx = 1'b0;
            end else begin
                if (stall_left == 0 && !steady_rx && $urandom_range(0, 3) == 0) begin
                    stall_left = pick_gap() + 1;
                end
                if (stall_left > 0) begin
                    m_tready <= 1'b0;
                    stall_left--;
                end else begin
                    m_tready <= 1'b1;
                end
            end
        end
    end

    initial begin
        #4_000_000;
        $display("substring_search_first_or_last_unit test failed");
        $finish;
    end

    initial begin
        int  sessions;
        bit  squeezed;
        int  waited;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = ACT_CLEAR;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = 1'b0;
        aresetn    = 1'b0;
        steady_tx  = 1'b0;
        steady_rx  = 1'b0;
        hold_rx    = 1'b0;
        words_sent = 0;
        sessions   = 0;
        squeezed   = 1'b0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // leftmost, no fold: empty pattern, extreme chars, case sensitivity
        send_word(ACT_FINISH, 16'hFFFF);
        send_word(ACT_TEXT, 16'h0000);
        send_word(ACT_TEXT, 16'hFFFF);
        send_word(ACT_FINISH, 16'h0000);
        send_word(ACT_APPEND, CHAR_UPPER_A);
        send_word(ACT_TEXT, CHAR_LOWER_A);
        send_word(ACT_TEXT, CHAR_UPPER_A);
        send_word(ACT_TEXT, CHAR_UPPER_A);
        send_word(ACT_FINISH, 16'h0000);
        send_word(ACT_CLEAR, 16'h0000);
        send_word(ACT_APPEND, 16'hFFFF);
        send_word(ACT_APPEND, 16'h0000);
        send_word(ACT_TEXT, 16'hFFFF);
        send_word(ACT_TEXT, 16'h0000);
        send_word(ACT_TEXT, 16'hFFFF);
        send_word(ACT_TEXT, 16'h0000);
        send_word(ACT_FINISH, 16'h0000);
        settle();
        set_regs(1'b1, 1'b1);

        // rightmost with fold: empty pattern gives text length, restart on append
        send_word(ACT_CLEAR, 16'h0000);
        send_word(ACT_TEXT, CHAR_UPPER_Z);
        send_word(ACT_TEXT, 16'h005B);
        send_word(ACT_FINISH, 16'h0000);
        send_word(ACT_APPEND, CHAR_LOWER_A);
        send_word(ACT_APPEND, CHAR_UPPER_Z);
        send_word(ACT_TEXT, CHAR_UPPER_A);
        send_word(ACT_TEXT, 16'h007A);
        send_word(ACT_TEXT, 16'h0040);
        send_word(ACT_TEXT, CHAR_LOWER_A);
        send_word(ACT_TEXT, CHAR_UPPER_Z);
        send_word(ACT_APPEND, 16'h0071);
        send_word(ACT_TEXT, CHAR_LOWER_A);
        send_word(ACT_TEXT, 16'h007A);
        send_word(ACT_TEXT, 16'h0051);
        send_word(ACT_FINISH, 16'h0000);

        while (words_sent < WORD_TARGET) begin
            if (sessions % 6 == 0) begin
                settle();
                set_regs(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                steady_tx = ($urandom_range(0, 3) == 0);
                steady_rx = ($urandom_range(0, 3) == 0);
            end
            if (!squeezed && words_sent > WORD_TARGET / 2) begin
                // output held off while finishes keep coming: input must back up
                settle();
                steady_tx = 1'b1;
                hold_rx   = 1'b1;
                send_word(ACT_CLEAR, 16'h0000);
                send_word(ACT_APPEND, 16'h0071);
                repeat (6) begin
                    send_word(ACT_TEXT, 16'h0071);
                    send_word(ACT_FINISH, 16'h0000);
                end
                settle();
                steady_tx = 1'b0;
                squeezed  = 1'b1;
            end
            run_session();
            sessions++;
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        for (waited = 0; due_count != 0 && waited < DRAIN_LIMIT; waited++) @(posedge aclk);
        repeat (END_CYCLES) @(posedge aclk);
        if (fail_count == 0 && due_count == 0) begin
            $display("substring_search_first_or_last_unit test passed");
        end else begin
            $display("substring_search_first_or_last_unit test failed");
        end
        $finish;
    end

endmodule
